FILE: hw/rtl/box_sum3_pkg.sv
// Shared constants of the 3x3 box sum stream block.
package box_sum3_pkg;

	// Default largest interior frame size and default sample width.
	localparam int DEF_MAX_SIZE    = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	// Frame size register.
	localparam int FRAME_SIZE_W = 11;
	localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = FRAME_SIZE_W'(64);

endpackage

FILE: hw/rtl/box_sum3_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module box_sum3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1026
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/box_sum_3x3_stream.sv
// Streaming 3x3 box sum over a padded square image with two line buffers.
//
// The block takes the samples of a square image of frame_size x frame_size interior positions
// with its one-sample border ring, row-major, starting at the top-left border corner, so each
// row holds frame_size+2 samples. It accepts one item per clock cycle while its output is not
// stalled and gives the exact sum of the nine samples around each interior position, with tlast
// on the last result of the frame. Each item waits in the input stage while its line buffer
// entry is read, and the sum of the window that it completes is then held in the output
// register, from which the result is offered. Items in the first two rows and the first two
// columns give no result. The line buffers need no clearing after reset,
// since every entry that a window reads has been written earlier in the same frame. Write
// frame_size only while the block is idle; a value of 0 acts as 1 and a value above MAX_SIZE
// acts as MAX_SIZE.
module box_sum_3x3_stream #(
	parameter int MAX_SIZE    = box_sum3_pkg::DEF_MAX_SIZE,
	parameter int SAMPLE_BITS = box_sum3_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Frame size register write.
	input  logic                                  cfg_we,
	input  logic [box_sum3_pkg::FRAME_SIZE_W-1:0] cfg_wdata,
	// Input samples.
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // sample
	// Results.
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((SAMPLE_BITS+4+7)/8)*8-1:0]    m_axis_tdata,  // box_sum, zero fill
	output logic                                  m_axis_tlast   // last_of_frame
);

	import box_sum3_pkg::*;

	localparam int DEPTH  = MAX_SIZE + 2;
	localparam int POS_W  = $clog2(DEPTH);
	localparam int CMP_W  = (FRAME_SIZE_W > POS_W) ? FRAME_SIZE_W : POS_W;
	localparam int COL_W  = SAMPLE_BITS + 2;
	localparam int SUM_W  = SAMPLE_BITS + 4;
	localparam int OUT_W  = ((SUM_W + 7) / 8) * 8;

	logic [FRAME_SIZE_W-1:0] frame_size_q;
	logic [POS_W-1:0]        col_q;
	logic [POS_W-1:0]        row_q;
	logic [CMP_W-1:0]        eff_size;
	logic [POS_W-1:0]        last_index;
	logic                    in_acc;

	logic                    valid_s1;
	logic [SAMPLE_BITS-1:0]  sample_s1;
	logic [POS_W-1:0]        addr_s1;
	logic                    produce_s1;
	logic                    last_s1;
	logic                    adv_s1;

	logic [2*SAMPLE_BITS-1:0] rd_data;
	logic [2*SAMPLE_BITS-1:0] wr_data;
	logic signed [COL_W-1:0]  column;
	logic signed [COL_W-1:0]  left_col_q;
	logic signed [COL_W-1:0]  mid_col_q;
	logic signed [SUM_W-1:0]  total;

	logic                    out_valid_q;
	logic [SUM_W-1:0]        box_sum_q;
	logic                    out_last_q;

	// Frame size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q <= FRAME_SIZE_RESET;
		end else if (cfg_we) begin
			frame_size_q <= cfg_wdata;
		end
	end

	// Clamp the frame size and find the index of the last border column and row.
	always_comb begin
		if (CMP_W'(frame_size_q) == CMP_W'(0)) begin
			eff_size = CMP_W'(1);
		end else if (CMP_W'(frame_size_q) > CMP_W'(MAX_SIZE)) begin
			eff_size = CMP_W'(MAX_SIZE);
		end else begin
			eff_size = CMP_W'(frame_size_q);
		end
		last_index = POS_W'(eff_size) + POS_W'(1);
	end

	// Handshake: stage 1 moves on whenever the output register is free or being emptied.
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Column and row position of the next item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_q >= last_index) begin
				col_q <= '0;
				if (row_q >= last_index) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + POS_W'(1);
				end
			end else begin
				col_q <= col_q + POS_W'(1);
				if (row_q > last_index) begin
					row_q <= '0;
				end
			end
		end
	end

	// Stage 1 control: an item waits here while its line buffer entry is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1  <= s_axis_tdata[SAMPLE_BITS-1:0];
			addr_s1    <= col_q;
			produce_s1 <= (row_q >= POS_W'(2)) && (col_q >= POS_W'(2));
			last_s1    <= (row_q == last_index) && (col_q == last_index);
		end
	end

	// Line buffers: the upper half holds the row two up, the lower half the row one up.
	assign wr_data = {rd_data[SAMPLE_BITS-1:0], sample_s1};

	box_sum3_ram #(
		.WIDTH (2 * SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (rd_data)
	);

	// Column sum of three vertically adjacent samples and the window total.
	always_comb begin
		column = COL_W'($signed(rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]))
			+ COL_W'($signed(rd_data[SAMPLE_BITS-1:0]))
			+ COL_W'($signed(sample_s1));
		total  = SUM_W'(left_col_q) + SUM_W'(mid_col_q) + SUM_W'(column);
	end

	// The last two column sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_col_q <= '0;
			mid_col_q  <= '0;
		end else if (adv_s1) begin
			left_col_q <= mid_col_q;
			mid_col_q  <= column;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= produce_s1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && produce_s1) begin
			box_sum_q  <= total;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(box_sum_q);
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: hw/rtl/box_sum3_checker.sv
// Port-level assertions for the 3x3 box sum stream block, bound to its top level.
module box_sum3_checker #(
	parameter int SAMPLE_BITS = box_sum3_pkg::DEF_SAMPLE_BITS
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_axis_tready,
	input logic                                  m_axis_tvalid,
	input logic                                  m_axis_tready,
	input logic [((SAMPLE_BITS+4+7)/8)*8-1:0]    m_axis_tdata,
	input logic                                  m_axis_tlast
);

	// A result that is not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result payload changed while stalled");

	// The block only stalls its input when its output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && !m_axis_tready) |-> s_axis_tready)
		else $error("input stalled with a free output");

	// A new result is never offered right after reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(!arst_n))
		else $error("result offered right after reset");

endmodule

bind box_sum_3x3_stream box_sum3_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_box_sum3_checker (.*);
